// File: rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths and cell types for the point-to-segment distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int FracBitsDefault = 14;
  localparam int CoordW          = 16;
  localparam int DistW           = 17;
  // Differences of two coordinates.
  localparam int DiffW           = CoordW + 1;
  // Dot products and squared lengths of differences.
  localparam int DotW            = 2 * DiffW + 1;
  // Squared length of the chosen vector (difference may grow by two bits).
  localparam int SqW             = 2 * (DiffW + 2) + 1;
  localparam int RootW           = SqW / 2 + 1;
  localparam logic [DistW-1:0] DistMax = '1;

  // Data carried along the divider cell chain.
  typedef struct packed {
    logic                     valid;
    logic [DotW-1:0]          rem;
    logic [DotW-1:0]          den;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [DiffW-1:0]  ex;
    logic signed [DiffW-1:0]  ey;
    logic signed [DiffW-1:0]  qx;
    logic signed [DiffW-1:0]  qy;
    logic [1:0]               sel;
  } div_cell_t;

  // Data carried along the square-root cell chain.
  typedef struct packed {
    logic              valid;
    logic [SqW-1:0]    rad;
    logic [RootW-1:0]  root;
  } sqrt_cell_t;

  localparam logic [1:0] SelStart = 2'd0;
  localparam logic [1:0] SelEnd   = 2'd1;
  localparam logic [1:0] SelFoot  = 2'd2;

endpackage

// File: rtl/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring-division step: produces one quotient bit of r.
// ----------------------------------------------------------------------------
module psd_div_cell
  import psd_pkg::*;
#(
  parameter int FracBits = FracBitsDefault,
  parameter int QW       = FracBits
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  div_cell_t       din,
  input  logic [QW-1:0]   qin,
  output div_cell_t       dout,
  output logic [QW-1:0]   qout
);

  logic [DotW:0]   trial;
  logic [DotW:0]   shifted;
  logic            take;

  // Shift the remainder and try to subtract the divisor.
  always_comb begin
    shifted = {din.rem, 1'b0};
    trial   = shifted - {1'b0, din.den};
    take    = ~trial[DotW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= take ? trial[DotW-1:0] : shifted[DotW-1:0];
      dout.den <= din.den;
      dout.dx  <= din.dx;
      dout.dy  <= din.dy;
      dout.ex  <= din.ex;
      dout.ey  <= din.ey;
      dout.qx  <= din.qx;
      dout.qy  <= din.qy;
      dout.sel <= din.sel;
      qout     <= {qin[QW-2:0], take};
    end
  end

endmodule

// File: rtl/psd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit step of a bit-by-bit integer square root.
// ----------------------------------------------------------------------------
module psd_sqrt_cell
  import psd_pkg::*;
#(
  parameter int Step = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  sqrt_cell_t  din,
  output sqrt_cell_t  dout
);

  localparam int Shift = 2 * (RootW - 1 - Step);

  logic [SqW+1:0] trial;
  logic [SqW+1:0] rad_ext;
  logic [SqW+1:0] cand;

  // Candidate (4*root+1) placed at this step's weight.
  always_comb begin
    cand    = ({{(SqW+2-RootW-2){1'b0}}, din.root, 2'b01}) << Shift;
    rad_ext = {2'b00, din.rad};
    trial   = rad_ext - cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!trial[SqW+1]) begin
        dout.rad  <= trial[SqW-1:0];
        dout.root <= {din.root[RootW-2:0], 1'b1};
      end else begin
        dout.rad  <= din.rad;
        dout.root <= {din.root[RootW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/point_segment_distance_core.sv
// ----------------------------------------------------------------------------
// point_segment_distance_core
// Distance from a point to a 2D segment, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one transfer per cycle unless stalled, returns one distance per item,
// in order. Stages: differences, products, dot products and selection, a
// chain of FRAC_BITS division cells for r, two stages for the foot-point
// product and squared length, square-root cells, one result bit each. The
// whole pipeline advances when the output register is free or taken.
module point_segment_distance_core
  import psd_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // point_x[15:0], point_y[31:16], start_x[47:32], start_y[63:48],
  // end_x[79:64], end_y[95:80]
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // distance[16:0], zero fill above
  output logic [23:0] m_tdata
);

  localparam int NSq = RootW;

  logic en;
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  // Stage 0: differences.
  logic                    v0;
  logic signed [DiffW-1:0] dx0, dy0, ex0, ey0, bx0, by0;
  logic signed [CoordW-1:0] px, py, ax, ay, bx, by;
  assign px = s_tdata[15:0];
  assign py = s_tdata[31:16];
  assign ax = s_tdata[47:32];
  assign ay = s_tdata[63:48];
  assign bx = s_tdata[79:64];
  assign by = s_tdata[95:80];

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx0 <= DiffW'(px) - DiffW'(ax);
      dy0 <= DiffW'(py) - DiffW'(ay);
      ex0 <= DiffW'(bx) - DiffW'(ax);
      ey0 <= DiffW'(by) - DiffW'(ay);
      bx0 <= DiffW'(px) - DiffW'(bx);
      by0 <= DiffW'(py) - DiffW'(by);
    end
  end

  // Stage 1: products.
  logic                    v1;
  logic signed [2*DiffW-1:0] pxe, pye, pee1, pee2;
  logic signed [DiffW-1:0] dx1, dy1, ex1, ey1, bx1, by1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pxe  <= dx0 * ex0;
      pye  <= dy0 * ey0;
      pee1 <= ex0 * ex0;
      pee2 <= ey0 * ey0;
      dx1 <= dx0; dy1 <= dy0; ex1 <= ex0; ey1 <= ey0; bx1 <= bx0; by1 <= by0;
    end
  end

  // Stage 2: dot products and case selection; loads the divider chain.
  div_cell_t               dc [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]    dq [FRAC_BITS+1];
  logic signed [DotW-1:0]  num;
  logic [DotW-1:0]         den;
  always_comb begin
    num = DotW'(pxe) + DotW'(pye);
    den = DotW'(unsigned'(pee1)) + DotW'(unsigned'(pee2));
  end

  always_ff @(posedge clk) begin
    if (rst) dc[0].valid <= 1'b0;
    else if (en) dc[0].valid <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dc[0].den <= den;
      dc[0].dx  <= dx1;
      dc[0].dy  <= dy1;
      dc[0].ex  <= ex1;
      dc[0].ey  <= ey1;
      dc[0].qx  <= bx1;
      dc[0].qy  <= by1;
      dq[0]     <= '0;
      if (den == '0 || num <= 0) begin
        dc[0].sel <= SelStart;
        dc[0].rem <= '0;
      end else if ($unsigned(num) >= den) begin
        dc[0].sel <= SelEnd;
        dc[0].rem <= '0;
      end else begin
        dc[0].sel <= SelFoot;
        dc[0].rem <= $unsigned(num);
      end
    end
  end

  // Division chain: one quotient bit per cell.
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    psd_div_cell #(.FracBits(FRAC_BITS), .QW(FRAC_BITS)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .din(dc[i]), .qin(dq[i]), .dout(dc[i+1]), .qout(dq[i+1])
    );
  end

  // Foot-point products.
  localparam int ProdW = DiffW + FRAC_BITS + 1;
  logic                    v3;
  logic signed [ProdW-1:0] tx, ty;
  logic signed [DiffW-1:0] dx3, dy3, qx3, qy3;
  logic [1:0]              sel3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= dc[FRAC_BITS].valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tx   <= ProdW'(dc[FRAC_BITS].ex) * ProdW'($signed({1'b0, dq[FRAC_BITS]}));
      ty   <= ProdW'(dc[FRAC_BITS].ey) * ProdW'($signed({1'b0, dq[FRAC_BITS]}));
      dx3  <= dc[FRAC_BITS].dx;
      dy3  <= dc[FRAC_BITS].dy;
      qx3  <= dc[FRAC_BITS].qx;
      qy3  <= dc[FRAC_BITS].qy;
      sel3 <= dc[FRAC_BITS].sel;
    end
  end

  // Choose the vector whose length is needed (arithmetic shift floors).
  localparam int VW = DiffW + 2;
  logic signed [VW-1:0] vx, vy;
  logic signed [ProdW-1:0] fx, fy;
  always_comb begin
    fx = tx >>> FRAC_BITS;
    fy = ty >>> FRAC_BITS;
    case (sel3)
      SelEnd: begin
        vx = VW'(qx3);
        vy = VW'(qy3);
      end
      SelFoot: begin
        vx = VW'(dx3) - VW'(fx);
        vy = VW'(dy3) - VW'(fy);
      end
      default: begin
        vx = VW'(dx3);
        vy = VW'(dy3);
      end
    endcase
  end

  // Squares, formed at full product width.
  logic                    v4;
  logic signed [2*VW-1:0]  sqx, sqy;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= vx * vx;
      sqy <= vy * vy;
    end
  end

  // Square-root chain, fed with the sum of squares.
  sqrt_cell_t sc [NSq+1];
  always_comb begin
    sc[0].valid = v4;
    sc[0].rad   = SqW'(sqx) + SqW'(sqy);
    sc[0].root  = '0;
  end

  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    psd_sqrt_cell #(.Step(k)) u_cell (
      .clk(clk), .rst(rst), .en(en), .din(sc[k]), .dout(sc[k+1])
    );
  end

  // Output register with saturation.
  logic [DistW-1:0] distance;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= sc[NSq].valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      distance <= (sc[NSq].root > RootW'(DistMax)) ? DistMax : sc[NSq].root[DistW-1:0];
    end
  end
  assign m_tdata = {7'd0, distance};

endmodule

// File: tb/sv/point_segment_distance_core_tb.sv
// ----------------------------------------------------------------------------
// point_segment_distance_core_tb
// Self-checking bench for the point-to-segment distance core.
// ----------------------------------------------------------------------------
// A queue of segment queries feeds a clocked driver. A clocked monitor takes
// each distance and compares it with the oldest predicted distance, which a
// bit-exact fixed-point model computes when the query transfer is accepted.
// Directed corner queries come first, then random queries of several shapes,
// with random idling on both sides, a long output hold-off and a drain pause.
module point_segment_distance_core_tb;
  import psd_pkg::*;

  localparam int Frac     = FracBitsDefault;
  localparam int Latency  = 3 + Frac + 3 + RootW;
  localparam int MaxCycles = 200000;
  localparam int NumRandom = 500;

  typedef struct packed {
    logic signed [15:0] end_y;
    logic signed [15:0] end_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_x;
  } query_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  query_t      pending_queries[$];
  logic [16:0] expected_distances[$];
  int          errors = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  bit          quiet_tail = 1'b0;
  bit          hold_sender = 1'b0;
  bit          long_holdoff_req = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          holdoff_left = 0;

  point_segment_distance_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root, rounded down.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [16:0] vector_length(longint x, longint y);
    longint unsigned r;
    r = root_floor(longint'(x * x) + longint'(y * y));
    return (r > 131071) ? 17'h1FFFF : r[16:0];
  endfunction

  // Arithmetic shift of a signed 64-bit value is a floor division.
  function automatic logic [16:0] predict_distance(query_t q);
    longint dx, dy, ex, ey, num, den, r, fx, fy;
    dx = longint'(q.point_x) - longint'(q.start_x);
    dy = longint'(q.point_y) - longint'(q.start_y);
    ex = longint'(q.end_x) - longint'(q.start_x);
    ey = longint'(q.end_y) - longint'(q.start_y);
    num = dx * ex + dy * ey;
    den = ex * ex + ey * ey;
    if (den == 0 || num <= 0) return vector_length(dx, dy);
    if (num >= den)
      return vector_length(longint'(q.point_x) - q.end_x, longint'(q.point_y) - q.end_y);
    r = (num << Frac) / den;
    fx = (ex * r) >>> Frac;
    fy = (ey * r) >>> Frac;
    return vector_length(dx - fx, dy - fy);
  endfunction

  function automatic logic signed [15:0] rand_coord(int shape);
    case (shape)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1) ? 16'sh7FFF - $urandom_range(0, 3)
                                        : -16'sh8000 + $urandom_range(0, 3));
      default: return 16'($signed($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  // Sender: one query per cycle unless idling, holding, stalled, or out of work.
  // The head of the queue is the query on the bus while s_tvalid is high.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_distances.push_back(predict_distance(query_t'(s_tdata)));
        void'(pending_queries.pop_front());
      end
      if (send_gap > 0) send_gap <= send_gap - 1;
      if (!quiet_tail && send_gap == 0 && $urandom_range(0, 15) == 0)
        send_gap <= $urandom_range(1, 10);
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (send_gap == 0 && !hold_sender && pending_queries.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_queries[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (holdoff_left > 0) begin
        holdoff_left <= holdoff_left - 1;
        m_tready <= 1'b0;
      end else if (long_holdoff_req) begin
        long_holdoff_req <= 1'b0;
        holdoff_left <= 3 * Latency;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_distances.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected distance transfer, actual %0d", $time, m_tdata[16:0]);
      end else begin
        if (m_tdata[16:0] !== expected_distances[0]) begin
          errors <= errors + 1;
          $display("%0t: distance mismatch, expected %0d actual %0d",
                   $time, expected_distances[0], m_tdata[16:0]);
        end
        void'(expected_distances.pop_front());
      end
    end
    if (cycle_count > MaxCycles) begin
      $display("%0t: timeout", $time);
      $display("** point_segment_distance_core: FAILED **");
      $finish;
    end
  end

  task automatic add_query(input logic signed [15:0] px, py, ax, ay, bx, by);
    query_t q;
    q.point_x = px; q.point_y = py; q.start_x = ax; q.start_y = ay;
    q.end_x = bx; q.end_y = by;
    pending_queries.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_queries.size() != 0 || s_tvalid || expected_distances.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    query_t q;
    int shape;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: extremes, degenerate segment, each side of the
    // projection, and the longest possible distance.
    add_query(0, 0, 0, 0, 0, 0);
    add_query(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    add_query(-16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    add_query(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    add_query(-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000);
    add_query(-100, 50, 0, 0, 1000, 0);
    add_query(1100, 50, 0, 0, 1000, 0);
    add_query(500, 50, 0, 0, 1000, 0);
    add_query(0, 77, 0, 0, 1000, 0);
    add_query(1000, -77, 0, 0, 1000, 0);
    add_query(333, 333, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF);
    add_query(-16'sh8000, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF);
    add_query(16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF);
    add_query(1, 1, 0, 0, 3, 1);
    add_query(-5, 7, 3, -2, -9, 11);
    add_query(16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
    add_query(16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 16'sh0F0F, -16'sh0F10);
    wait_drained();

    // Long output hold-off with the sender still offering.
    long_holdoff_req = 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      shape = $urandom_range(0, 9);
      q = query_t'({$urandom, $urandom, $urandom});
      if (shape == 0) begin
        q.end_x = q.start_x; q.end_y = q.start_y;
      end else if (shape < 3) begin
        q.point_x = rand_coord(1); q.point_y = rand_coord(1);
        q.start_x = rand_coord(1); q.start_y = rand_coord(1);
        q.end_x = rand_coord(1);   q.end_y = rand_coord(1);
      end else if (shape < 6) begin
        q.point_x = rand_coord(2); q.point_y = rand_coord(2);
        q.start_x = rand_coord(2); q.start_y = rand_coord(2);
        q.end_x = rand_coord(2);   q.end_y = rand_coord(2);
      end
      pending_queries.push_back(q);
      if (i == NumRandom / 2) begin
        // No new queries are queued until every expected distance has come back.
        wait_drained();
        hold_sender = 1'b0;
      end
      if (i == NumRandom - 60) begin
        wait_drained();
        quiet_tail = 1'b1;
      end
    end
    wait_drained();
    repeat (Latency + 10) @(posedge clk);

    $display("Checked %0d distances: corner segments, degenerate segments,", results_seen);
    $display("near-full-scale and random coordinates, under stalls on both sides.");
    if (errors == 0 && expected_distances.size() == 0) begin
      $display("** point_segment_distance_core: PASSED **");
    end else begin
      $display("** point_segment_distance_core: FAILED **");
    end
    $finish;
  end

endmodule
